[rtl/core/afs_pkg.sv]
// Shared types, constants and register codes of the animation frame stepper.
`timescale 1ns / 1ps

package afs_pkg;

  localparam int FRAME_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int SPEED_W     = 24;
  localparam int SPEED_FRAC  = 16;
  localparam int TIME_W      = 32;
  localparam int CFG_FRAME_W = 10;
  localparam int RATE_W      = 16;
  localparam int BLEND_W     = 17;
  localparam int INDEX_OUT_W = 10;
  localparam int FRACT_OUT_W = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [BLEND_W-1:0]     BLEND_ONE   = 17'h10000;
  localparam logic [FRACT_OUT_W-1:0] FRACT_SCALE = 10'd1000;

  localparam logic [CFG_FRAME_W-1:0] START_RST = 10'd0;
  localparam logic [CFG_FRAME_W-1:0] END_RST   = 10'd10;
  localparam logic [SPEED_W-1:0]     SPEED_RST = 24'd1638;
  localparam logic                   LOOP_RST  = 1'b1;
  localparam logic [RATE_W-1:0]      RATE_RST  = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START = 3'd0,
    CFG_END   = 3'd1,
    CFG_SPEED = 3'd2,
    CFG_LOOP  = 3'd3,
    CFG_RATE  = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } opcode_e;

  typedef enum logic {
    ARITH_MUL = 1'b0,
    ARITH_MOD = 1'b1
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_cmd_t;

  typedef struct packed {
    logic [CFG_FRAME_W-1:0] start_frame;
    logic [CFG_FRAME_W-1:0] end_frame;
    logic [SPEED_W-1:0]     speed;
    logic                   looping;
    logic [RATE_W-1:0]      rate;
  } afs_cfg_t;

endpackage

[rtl/core/afs_unit.sv]
// Shared shift-add multiplier and restoring remainder unit, one bit per cycle.
`timescale 1ns / 1ps

module afs_unit import afs_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  arith_cmd_t                                   cmd_i,
  input  logic [TIME_W-1:0]                            mcand_i,
  input  logic [SPEED_W-1:0]                           mplr_i,
  input  logic [SPEED_W+TIME_W+FRAC_BITS-SPEED_FRAC:0] dvnd_i,
  input  logic [FRAME_BITS+FRAC_BITS-1:0]              dvsr_i,
  output logic [SPEED_W+TIME_W-1:0]                    prod_o,
  output logic [FRAME_BITS+FRAC_BITS-1:0]              rem_o,
  output logic                                         done_o
);

  localparam int POS_W  = FRAME_BITS + FRAC_BITS;
  localparam int PROD_W = SPEED_W + TIME_W;
  localparam int DIV_W  = PROD_W + FRAC_BITS - SPEED_FRAC + 1;
  localparam int ACC_W  = (DIV_W > PROD_W) ? DIV_W : PROD_W;
  localparam int CNT_W  = $clog2(ACC_W + 1);

  arith_op_e          op_q;
  logic               busy_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [ACC_W-1:0]   acc_q;
  logic [SPEED_W-1:0] mplr_q;
  logic [POS_W-1:0]   rem_q;

  logic [ACC_W-1:0] acc_shl;
  logic [ACC_W-1:0] mul_d;
  logic [POS_W:0]   trial;
  logic [POS_W:0]   trial_sub;
  logic [POS_W:0]   rem_d;

  assign acc_shl   = {acc_q[ACC_W-2:0], 1'b0};
  assign mul_d     = acc_shl + (mplr_q[SPEED_W-1] ? ACC_W'(mcand_i) : '0);
  assign trial     = {rem_q, acc_q[ACC_W-1]};
  assign trial_sub = trial - {1'b0, dvsr_i};
  assign rem_d     = (trial >= {1'b0, dvsr_i}) ? trial_sub : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= ARITH_MUL;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
      mplr_q <= '0;
      rem_q  <= '0;
    end else if (cmd_i.start) begin
      op_q   <= cmd_i.op;
      busy_q <= 1'b1;
      done_q <= 1'b0;
      unique case (cmd_i.op)
        ARITH_MUL: begin
          cnt_q  <= CNT_W'(SPEED_W);
          acc_q  <= '0;
          mplr_q <= mplr_i;
        end
        ARITH_MOD: begin
          cnt_q <= CNT_W'(DIV_W);
          acc_q <= ACC_W'(dvnd_i) << (ACC_W - DIV_W);
          rem_q <= '0;
        end
        default: begin
          cnt_q <= '0;
        end
      endcase
    end else if (busy_q) begin
      unique case (op_q)
        ARITH_MUL: begin
          acc_q  <= mul_d;
          mplr_q <= {mplr_q[SPEED_W-2:0], 1'b0};
        end
        ARITH_MOD: begin
          acc_q <= acc_shl;
          rem_q <= rem_d[POS_W-1:0];
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign prod_o = acc_q[PROD_W-1:0];
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

[rtl/core/afs_ctrl.sv]
// Item sequencer: frame position, time and blend state, and the result register.
`timescale 1ns / 1ps

module afs_ctrl import afs_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  afs_cfg_t                                     cfg_i,
  input  logic                                         in_valid_i,
  output logic                                         in_ready_o,
  input  logic                                         opcode_i,
  input  logic [TIME_W-1:0]                            time_ms_i,
  input  logic [FRAME_BITS+FRAC_BITS-1:0]              frame_value_i,
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output logic [INDEX_OUT_W-1:0]                       frame_index_o,
  output logic [FRACT_OUT_W-1:0]                       frame_fraction_o,
  output logic [BLEND_W-1:0]                           transition_blend_o,
  output logic                                         transiting_o,
  output arith_cmd_t                                   cmd_o,
  output logic [TIME_W-1:0]                            mcand_o,
  output logic [SPEED_W-1:0]                           mplr_o,
  output logic [SPEED_W+TIME_W+FRAC_BITS-SPEED_FRAC:0] dvnd_o,
  output logic [FRAME_BITS+FRAC_BITS-1:0]              dvsr_o,
  input  logic [SPEED_W+TIME_W-1:0]                    prod_i,
  input  logic [FRAME_BITS+FRAC_BITS-1:0]              rem_i,
  input  logic                                         done_i
);

  localparam int POS_W  = FRAME_BITS + FRAC_BITS;
  localparam int PROD_W = SPEED_W + TIME_W;
  localparam int MAG_W  = PROD_W + FRAC_BITS - SPEED_FRAC;
  localparam int DIV_W  = MAG_W + 1;
  localparam int BSUM_W = TIME_W + RATE_W + 1;
  localparam int FMUL_W = FRAC_BITS + FRACT_OUT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLEND,
    ST_STEP,
    ST_WRAP,
    ST_DONE
  } state_e;

  state_e             state_q;
  arith_cmd_t         cmd_q;
  logic [POS_W-1:0]   pos_q;
  logic [TIME_W-1:0]  last_q;
  logic               active_q;
  logic [BLEND_W-1:0] blend_q;
  logic [TIME_W-1:0]  dt_q;
  logic [DIV_W-1:0]   dvnd_q;
  logic               fwd_q;

  logic                   out_valid_q;
  logic [INDEX_OUT_W-1:0] index_q;
  logic [FRACT_OUT_W-1:0] fract_q;
  logic [BLEND_W-1:0]     oblend_q;
  logic                   otrans_q;

  logic [FRAME_BITS+CFG_FRAME_W-1:0] start_x;
  logic [FRAME_BITS+CFG_FRAME_W-1:0] end_x;
  logic [POS_W-1:0]                  s_pos;
  logic [POS_W-1:0]                  e_pos;
  logic [SPEED_W-1:0]                abs_speed;
  logic                              fwd;
  logic [PROD_W+FRAC_BITS-1:0]       prod_x;
  logic [MAG_W-1:0]                  mag;
  logic [DIV_W-1:0]                  nv;
  logic [DIV_W-1:0]                  bdiff;
  logic                              bwrap;
  logic [DIV_W-1:0]                  fdvnd;
  logic [DIV_W-1:0]                  bdvnd;
  logic [BSUM_W-1:0]                 blend_sum;
  logic [POS_W-1:0]                  v_lo;
  logic [POS_W-1:0]                  v_cl;
  logic [TIME_W-1:0]                 dt_new;
  logic [FMUL_W-1:0]                 frac_mul;
  logic [FRAME_BITS+INDEX_OUT_W-1:0] idx_x;
  logic                              accept;

  assign start_x = {FRAME_BITS'(0), cfg_i.start_frame};
  assign end_x   = {FRAME_BITS'(0), cfg_i.end_frame};
  assign s_pos   = {start_x[FRAME_BITS-1:0], FRAC_BITS'(0)};
  assign e_pos   = {end_x[FRAME_BITS-1:0], FRAC_BITS'(0)};

  assign abs_speed = cfg_i.speed[SPEED_W-1] ? (~cfg_i.speed + 1'b1) : cfg_i.speed;
  assign fwd       = !cfg_i.speed[SPEED_W-1] && (cfg_i.speed != '0);

  assign prod_x = {prod_i, FRAC_BITS'(0)};
  assign mag    = prod_x[PROD_W+FRAC_BITS-1:SPEED_FRAC];

  assign nv    = DIV_W'(pos_q) + DIV_W'(mag);
  assign bdiff = DIV_W'(pos_q) - DIV_W'(mag);
  assign bwrap = (DIV_W'(mag) > DIV_W'(pos_q)) || (bdiff < DIV_W'(s_pos));
  assign fdvnd = nv - DIV_W'(s_pos);
  assign bdvnd = DIV_W'(e_pos) + DIV_W'(mag) - DIV_W'(pos_q);

  assign blend_sum = BSUM_W'(blend_q) + BSUM_W'(prod_i[TIME_W+RATE_W-1:0]);

  assign v_lo   = (frame_value_i < s_pos) ? s_pos : frame_value_i;
  assign v_cl   = (v_lo > e_pos) ? e_pos : v_lo;
  assign dt_new = (last_q == '0) ? '0 : (time_ms_i - last_q);

  assign frac_mul = FMUL_W'(pos_q[FRAC_BITS-1:0]) * FMUL_W'(FRACT_SCALE);
  assign idx_x    = {INDEX_OUT_W'(0), pos_q[POS_W-1:FRAC_BITS]};

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '{start: 1'b0, op: ARITH_MUL};
      pos_q       <= '0;
      last_q      <= '0;
      active_q    <= 1'b0;
      blend_q     <= '0;
      dt_q        <= '0;
      dvnd_q      <= '0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      index_q     <= '0;
      fract_q     <= '0;
      oblend_q    <= '0;
      otrans_q    <= 1'b0;
    end else begin
      if (cmd_q.start) begin
        cmd_q.start <= 1'b0;
      end
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (opcode_e'(opcode_i) == OP_SET) begin
              pos_q <= v_cl;
              if (cfg_i.rate != '0) begin
                active_q <= 1'b1;
                blend_q  <= '0;
              end
              state_q <= ST_DONE;
            end else begin
              dt_q    <= dt_new;
              last_q  <= time_ms_i;
              cmd_q   <= '{start: 1'b1, op: ARITH_MUL};
              state_q <= active_q ? ST_BLEND : ST_STEP;
            end
          end
        end
        ST_BLEND: begin
          if (done_i) begin
            if (blend_sum > BSUM_W'(BLEND_ONE)) begin
              active_q <= 1'b0;
              blend_q  <= '0;
            end else begin
              blend_q <= blend_sum[BLEND_W-1:0];
            end
            cmd_q   <= '{start: 1'b1, op: ARITH_MUL};
            state_q <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (done_i) begin
            if (e_pos <= s_pos) begin
              pos_q   <= s_pos;
              state_q <= ST_DONE;
            end else if (fwd) begin
              if (nv > DIV_W'(e_pos)) begin
                if (cfg_i.looping) begin
                  dvnd_q  <= fdvnd;
                  fwd_q   <= 1'b1;
                  cmd_q   <= '{start: 1'b1, op: ARITH_MOD};
                  state_q <= ST_WRAP;
                end else begin
                  pos_q   <= e_pos;
                  state_q <= ST_DONE;
                end
              end else begin
                pos_q   <= nv[POS_W-1:0];
                state_q <= ST_DONE;
              end
            end else begin
              if (bwrap) begin
                if (cfg_i.looping) begin
                  dvnd_q  <= bdvnd;
                  fwd_q   <= 1'b0;
                  cmd_q   <= '{start: 1'b1, op: ARITH_MOD};
                  state_q <= ST_WRAP;
                end else begin
                  pos_q   <= s_pos;
                  state_q <= ST_DONE;
                end
              end else begin
                pos_q   <= bdiff[POS_W-1:0];
                state_q <= ST_DONE;
              end
            end
          end
        end
        ST_WRAP: begin
          if (done_i) begin
            pos_q   <= fwd_q ? (s_pos + rem_i) : (e_pos - rem_i);
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            index_q     <= idx_x[INDEX_OUT_W-1:0];
            fract_q     <= frac_mul[FMUL_W-1:FRAC_BITS];
            oblend_q    <= blend_q;
            otrans_q    <= active_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign frame_index_o      = index_q;
  assign frame_fraction_o   = fract_q;
  assign transition_blend_o = oblend_q;
  assign transiting_o       = otrans_q;

  assign cmd_o   = cmd_q;
  assign mcand_o = dt_q;
  assign mplr_o  = (state_q == ST_BLEND) ? SPEED_W'(cfg_i.rate) : abs_speed;
  assign dvnd_o  = dvnd_q;
  assign dvsr_o  = e_pos - s_pos;

endmodule

[rtl/core/animation_frame_stepper.sv]
// Top level of the animation frame stepper: configuration registers and core.
//
//  channel  direction  transfer when             payload
//  in       input      in_valid_i & in_ready_o   opcode_i, time_ms_i, frame_value_i
//  out      output     out_valid_o & out_ready_i frame_index_o, frame_fraction_o,
//                                                transition_blend_o, transiting_o
//  cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A set-frame item needs no arithmetic. A tick runs the step multiply, after the
// blend multiply while a transition runs, and a remainder pass over the Q10.16
// frame range when the frame wraps: the shared unit resolves one bit a cycle.
// One item is in work at a time; in_ready_o is low until its result is loaded.
// A result waiting in the output register does not block the next transfer in.
// Reset is asynchronous and needs no clearing pass.
`timescale 1ns / 1ps

module animation_frame_stepper import afs_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [CFG_IDX_W-1:0]            cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]           cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            opcode_i,
  input  logic [TIME_W-1:0]               time_ms_i,
  input  logic [FRAME_BITS+FRAC_BITS-1:0] frame_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [INDEX_OUT_W-1:0]          frame_index_o,
  output logic [FRACT_OUT_W-1:0]          frame_fraction_o,
  output logic [BLEND_W-1:0]              transition_blend_o,
  output logic                            transiting_o
);

  localparam int POS_W  = FRAME_BITS + FRAC_BITS;
  localparam int PROD_W = SPEED_W + TIME_W;
  localparam int DIV_W  = PROD_W + FRAC_BITS - SPEED_FRAC + 1;

  logic [CFG_FRAME_W-1:0] start_q;
  logic [CFG_FRAME_W-1:0] end_q;
  logic [SPEED_W-1:0]     speed_q;
  logic                   loop_q;
  logic [RATE_W-1:0]      rate_q;

  afs_cfg_t          cfg;
  arith_cmd_t        cmd;
  logic [TIME_W-1:0] mcand;
  logic [SPEED_W-1:0] mplr;
  logic [DIV_W-1:0]  dvnd;
  logic [POS_W-1:0]  dvsr;
  logic [PROD_W-1:0] prod;
  logic [POS_W-1:0]  rem;
  logic              done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_RST;
      end_q   <= END_RST;
      speed_q <= SPEED_RST;
      loop_q  <= LOOP_RST;
      rate_q  <= RATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START: start_q <= cfg_data_i[CFG_FRAME_W-1:0];
        CFG_END:   end_q   <= cfg_data_i[CFG_FRAME_W-1:0];
        CFG_SPEED: speed_q <= cfg_data_i[SPEED_W-1:0];
        CFG_LOOP:  loop_q  <= cfg_data_i[0];
        CFG_RATE:  rate_q  <= cfg_data_i[RATE_W-1:0];
        default: begin
          // drop writes to unused indexes
          rate_q <= rate_q;
        end
      endcase
    end
  end

  assign cfg = '{
    start_frame: start_q,
    end_frame:   end_q,
    speed:       speed_q,
    looping:     loop_q,
    rate:        rate_q
  };

  afs_ctrl #(
    .FRAME_BITS(FRAME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .opcode_i          (opcode_i),
    .time_ms_i         (time_ms_i),
    .frame_value_i     (frame_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .frame_index_o     (frame_index_o),
    .frame_fraction_o  (frame_fraction_o),
    .transition_blend_o(transition_blend_o),
    .transiting_o      (transiting_o),
    .cmd_o             (cmd),
    .mcand_o           (mcand),
    .mplr_o            (mplr),
    .dvnd_o            (dvnd),
    .dvsr_o            (dvsr),
    .prod_i            (prod),
    .rem_i             (rem),
    .done_i            (done)
  );

  afs_unit #(
    .FRAME_BITS(FRAME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .mcand_i(mcand),
    .mplr_i (mplr),
    .dvnd_i (dvnd),
    .dvsr_i (dvsr),
    .prod_o (prod),
    .rem_o  (rem),
    .done_o (done)
  );

endmodule
